[hdl/lass_pkg.sv]
// ----------------------------------------------------------------------------
// lass_pkg - shared types for the least-attained-service scheduler
// Field widths of the item channels and the command broadcast to the cells.
// ----------------------------------------------------------------------------
package lass_pkg;

    localparam int LEN_W  = 16;
    localparam int TAG_W  = 16;
    localparam int CNT_W  = 32;
    localparam int FLOW_W = 4;

    // command broadcast from the sequencer to every flow cell
    typedef struct packed {
        logic             enq;
        logic             pop;
        logic             add;
        logic [LEN_W-1:0] plen;
    } lass_cmd_t;

endpackage

[hdl/lass_in_if.sv]
// ----------------------------------------------------------------------------
// lass_in_if - request channel
// Carries one enqueue or dequeue item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lass_in_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [lass_pkg::FLOW_W-1:0] flow_index;
    logic [lass_pkg::LEN_W-1:0]  packet_length;
    logic [lass_pkg::TAG_W-1:0]  packet_tag;

    modport source (output valid, mode, flow_index, packet_length, packet_tag,
                    input ready);
    modport sink   (input valid, mode, flow_index, packet_length, packet_tag,
                    output ready);
endinterface

[hdl/lass_out_if.sv]
// ----------------------------------------------------------------------------
// lass_out_if - result channel
// Carries one result item per request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lass_out_if;
    logic                        valid;
    logic                        ready;
    logic                        out_valid;
    logic [lass_pkg::FLOW_W-1:0] out_flow;
    logic [lass_pkg::LEN_W-1:0]  out_length;
    logic [lass_pkg::TAG_W-1:0]  out_tag;
    logic                        dropped;
    logic                        all_empty;

    modport source (output valid, out_valid, out_flow, out_length, out_tag, dropped,
                    all_empty, input ready);
    modport sink   (input valid, out_valid, out_flow, out_length, out_tag, dropped,
                    all_empty, output ready);
endinterface

[hdl/lass_cell.sv]
// ----------------------------------------------------------------------------
// lass_cell - one flow of the scheduler
// Holds the flow's service count, fill and ring pointers, and takes part in
// the minimum search that ripples one cell per cycle along the row.
// ----------------------------------------------------------------------------
module lass_cell #(
    parameter int IDX     = 0,
    parameter int IDX_W   = 4,
    parameter int PTR_W   = 4,
    parameter int FILL_W  = 5,
    parameter int DEPTH   = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lass_pkg::lass_cmd_t         cmd,
    input  logic                        sel,
    input  logic                        tok_in,
    input  logic                        found_in,
    input  logic [IDX_W-1:0]            flow_in,
    input  logic [lass_pkg::CNT_W-1:0]  count_in,
    output logic                        tok_out,
    output logic                        found_out,
    output logic [IDX_W-1:0]            flow_out,
    output logic [lass_pkg::CNT_W-1:0]  count_out,
    output logic                        full,
    output logic [PTR_W-1:0]            head,
    output logic [PTR_W-1:0]            tail
);
    logic [lass_pkg::CNT_W-1:0] count_reg;
    logic [FILL_W-1:0]          fill_reg;
    logic [PTR_W-1:0]           head_reg;
    logic [PTR_W-1:0]           tail_reg;
    logic                       tok_reg;
    logic                       found_reg;
    logic [IDX_W-1:0]           flow_reg;
    logic [lass_pkg::CNT_W-1:0] cnt_reg;
    logic                       take;
    logic [lass_pkg::CNT_W:0]   sum;

    assign take = tok_in && (fill_reg != '0) && (!found_in || count_reg < count_in);
    assign sum  = {1'b0, count_reg} + {{(lass_pkg::CNT_W + 1 - lass_pkg::LEN_W){1'b0}},
                  cmd.plen};
    assign full = (fill_reg == FILL_W'(DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            fill_reg  <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            tok_reg   <= 1'b0;
            found_reg <= 1'b0;
            flow_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            // advance the search candidate to the next cell
            tok_reg   <= tok_in;
            found_reg <= found_in || take;
            flow_reg  <= take ? IDX_W'(IDX) : flow_in;
            cnt_reg   <= take ? count_reg : count_in;
            if (sel && cmd.enq)
            begin
                tail_reg <= (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                fill_reg <= fill_reg + 1'b1;
            end
            if (sel && cmd.pop)
            begin
                head_reg <= (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
                fill_reg <= fill_reg - 1'b1;
            end
            if (sel && cmd.add)
            begin
                // clear once drained, else add the length, saturating
                if (fill_reg == '0)
                    count_reg <= '0;
                else if (sum[lass_pkg::CNT_W])
                    count_reg <= '1;
                else
                    count_reg <= sum[lass_pkg::CNT_W-1:0];
            end
        end
    end

    assign tok_out   = tok_reg;
    assign found_out = found_reg;
    assign flow_out  = flow_reg;
    assign count_out = cnt_reg;
    assign head      = head_reg;
    assign tail      = tail_reg;
endmodule

[hdl/least_attained_service_scheduler_core.sv]
// ----------------------------------------------------------------------------
// least_attained_service_scheduler_core - least-attained-service scheduler
// Per-flow packet FIFOs in one shared store, one cell per flow in a row.
// ----------------------------------------------------------------------------
// One request item is worked on at a time and gives exactly one result item.
// An enqueue passes through ST_ENQ to ST_OUT. A dequeue passes through ST_START
// and ST_WAIT, the minimum search, which passes a candidate along the row of
// flow cells one cell per cycle, then ST_POP, the read of the shared packet
// store, and ST_ADD, the update of the chosen flow's service count, to ST_OUT;
// when nothing waits it goes from ST_WAIT straight to ST_OUT.
// A finished result waits in the output register while the next request is
// already accepted. The packet store has no reset; only written slots are read.
module least_attained_service_scheduler_core #(
    parameter int NUM_FLOWS   = 16,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    lass_in_if.sink   req,
    lass_out_if.source res
);
    localparam int IDX_W   = $clog2(NUM_FLOWS);
    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRIES = NUM_FLOWS * QUEUE_DEPTH;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int TOT_W   = $clog2(ENTRIES + 1);
    localparam int WORD_W  = lass_pkg::LEN_W + lass_pkg::TAG_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ENQ, ST_START, ST_WAIT, ST_POP, ST_ADD, ST_OUT
    } state_t;

    state_t                      state_reg;
    logic [lass_pkg::FLOW_W-1:0] flow_reg;
    logic [lass_pkg::LEN_W-1:0]  len_reg;
    logic [lass_pkg::TAG_W-1:0]  tag_reg;
    logic [IDX_W-1:0]            best_reg;
    logic [TOT_W-1:0]            total_reg;
    logic [WORD_W-1:0]           rd_reg;
    logic [WORD_W-1:0]           mem [ENTRIES];

    // result held until the output register is free
    logic                        rv_reg;
    logic [lass_pkg::FLOW_W-1:0] rf_reg;
    logic [lass_pkg::LEN_W-1:0]  rl_reg;
    logic [lass_pkg::TAG_W-1:0]  rt_reg;
    logic                        rd_drop_reg;
    logic                        re_reg;

    logic                        ov_reg;
    logic                        oval_reg;
    logic [lass_pkg::FLOW_W-1:0] oflow_reg;
    logic [lass_pkg::LEN_W-1:0]  olen_reg;
    logic [lass_pkg::TAG_W-1:0]  otag_reg;
    logic                        odrop_reg;
    logic                        oempty_reg;

    lass_pkg::lass_cmd_t         cmd;
    logic [NUM_FLOWS-1:0]        sel_vec;
    logic                        tok   [NUM_FLOWS+1];
    logic                        found [NUM_FLOWS+1];
    logic [IDX_W-1:0]            cflow [NUM_FLOWS+1];
    logic [lass_pkg::CNT_W-1:0]  ccnt  [NUM_FLOWS+1];
    logic [NUM_FLOWS-1:0]        full_vec;
    logic [PTR_W-1:0]            head_arr [NUM_FLOWS];
    logic [PTR_W-1:0]            tail_arr [NUM_FLOWS];
    logic [PTR_W-1:0]            head_sel;
    logic [PTR_W-1:0]            tail_sel;
    logic                        in_range;
    logic                        drop;
    logic [ADDR_W-1:0]           wr_addr;
    logic [ADDR_W-1:0]           rd_addr;
    logic                        out_free;

    assign req.ready = (state_reg == ST_IDLE);
    assign in_range  = (32'(flow_reg) < NUM_FLOWS);
    assign out_free  = !ov_reg || res.ready;

    // flow select: the enqueue flow, or the search winner for pop and add
    always_comb
    begin
        for (int i = 0; i < NUM_FLOWS; i++)
        begin
            if (state_reg == ST_ENQ)
                sel_vec[i] = (32'(flow_reg) == i);
            else
                sel_vec[i] = (32'(best_reg) == i);
        end
    end

    always_comb
    begin
        head_sel = '0;
        tail_sel = '0;
        for (int i = 0; i < NUM_FLOWS; i++)
        begin
            head_sel = head_sel | (sel_vec[i] ? head_arr[i] : '0);
            tail_sel = tail_sel | (sel_vec[i] ? tail_arr[i] : '0);
        end
    end

    assign drop    = !in_range || ((sel_vec & full_vec) != '0);
    assign wr_addr = ADDR_W'(ADDR_W'(IDX_W'(flow_reg)) * ADDR_W'(QUEUE_DEPTH))
                     + ADDR_W'(tail_sel);
    assign rd_addr = ADDR_W'(ADDR_W'(best_reg) * ADDR_W'(QUEUE_DEPTH))
                     + ADDR_W'(head_sel);

    always_comb
    begin
        cmd.enq  = (state_reg == ST_ENQ) && !drop;
        cmd.pop  = (state_reg == ST_POP);
        cmd.add  = (state_reg == ST_ADD);
        cmd.plen = rd_reg[WORD_W-1:lass_pkg::TAG_W];
    end

    // head of the search chain: no candidate yet
    assign tok[0]   = (state_reg == ST_START);
    assign found[0] = 1'b0;
    assign cflow[0] = '0;
    assign ccnt[0]  = '0;

    for (genvar g = 0; g < NUM_FLOWS; g++)
    begin : g_cell
        lass_cell #(
            .IDX    (g),
            .IDX_W  (IDX_W),
            .PTR_W  (PTR_W),
            .FILL_W (FILL_W),
            .DEPTH  (QUEUE_DEPTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .sel       (sel_vec[g]),
            .tok_in    (tok[g]),
            .found_in  (found[g]),
            .flow_in   (cflow[g]),
            .count_in  (ccnt[g]),
            .tok_out   (tok[g+1]),
            .found_out (found[g+1]),
            .flow_out  (cflow[g+1]),
            .count_out (ccnt[g+1]),
            .full      (full_vec[g]),
            .head      (head_arr[g]),
            .tail      (tail_arr[g])
        );
    end

    // shared packet store: length in the upper half, tag in the lower
    always_ff @(posedge clk)
    begin
        if (cmd.enq)
            mem[wr_addr] <= {len_reg, tag_reg};
        if (state_reg == ST_POP)
            rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            flow_reg    <= '0;
            len_reg     <= '0;
            tag_reg     <= '0;
            best_reg    <= '0;
            total_reg   <= '0;
            rv_reg      <= 1'b0;
            rf_reg      <= '0;
            rl_reg      <= '0;
            rt_reg      <= '0;
            rd_drop_reg <= 1'b0;
            re_reg      <= 1'b0;
            ov_reg      <= 1'b0;
            oval_reg    <= 1'b0;
            oflow_reg   <= '0;
            olen_reg    <= '0;
            otag_reg    <= '0;
            odrop_reg   <= 1'b0;
            oempty_reg  <= 1'b0;
        end
        else
        begin
            if (ov_reg && res.ready)
                ov_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        flow_reg  <= req.flow_index;
                        len_reg   <= req.packet_length;
                        tag_reg   <= req.packet_tag;
                        state_reg <= req.mode ? ST_START : ST_ENQ;
                    end
                end
                ST_ENQ:
                begin
                    rv_reg      <= 1'b0;
                    rf_reg      <= '0;
                    rl_reg      <= '0;
                    rt_reg      <= '0;
                    rd_drop_reg <= drop;
                    if (drop)
                        re_reg <= (total_reg == '0);
                    else
                    begin
                        re_reg    <= 1'b0;
                        total_reg <= total_reg + 1'b1;
                    end
                    state_reg <= ST_OUT;
                end
                ST_START:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    // wait for the candidate to leave the last cell
                    if (tok[NUM_FLOWS])
                    begin
                        best_reg <= cflow[NUM_FLOWS];
                        if (found[NUM_FLOWS])
                            state_reg <= ST_POP;
                        else
                        begin
                            rv_reg      <= 1'b0;
                            rf_reg      <= '0;
                            rl_reg      <= '0;
                            rt_reg      <= '0;
                            rd_drop_reg <= 1'b0;
                            re_reg      <= 1'b1;
                            state_reg   <= ST_OUT;
                        end
                    end
                end
                ST_POP:
                begin
                    total_reg <= total_reg - 1'b1;
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    rv_reg      <= 1'b1;
                    rf_reg      <= lass_pkg::FLOW_W'(best_reg);
                    rl_reg      <= rd_reg[WORD_W-1:lass_pkg::TAG_W];
                    rt_reg      <= rd_reg[lass_pkg::TAG_W-1:0];
                    rd_drop_reg <= 1'b0;
                    re_reg      <= (total_reg == '0);
                    state_reg   <= ST_OUT;
                end
                ST_OUT:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        ov_reg     <= 1'b1;
                        oval_reg   <= rv_reg;
                        oflow_reg  <= rf_reg;
                        olen_reg   <= rl_reg;
                        otag_reg   <= rt_reg;
                        odrop_reg  <= rd_drop_reg;
                        oempty_reg <= re_reg;
                        state_reg  <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res.valid      = ov_reg;
    assign res.out_valid  = oval_reg;
    assign res.out_flow   = oflow_reg;
    assign res.out_length = olen_reg;
    assign res.out_tag    = otag_reg;
    assign res.dropped    = odrop_reg;
    assign res.all_empty  = oempty_reg;

    a_tok_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        tok[NUM_FLOWS] |-> state_reg == ST_WAIT)
        else $error("search candidate left the row outside the wait state");

    a_add_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ADD |-> $past(state_reg) == ST_POP)
        else $error("service update without a preceding pop");

    a_no_drop_on_dequeue: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.out_valid |-> !res.dropped && !res.all_empty
            || !res.dropped)
        else $error("dequeued packet flagged as dropped");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(total_reg) <= ENTRIES)
        else $error("packet count exceeds store size");
endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb - testbench for the least-attained-service scheduler core
// Drives enqueue and dequeue items through the request channel and checks
// each result item against a cycle-free model of the flow queues. Directed
// rows come first, then random traffic under several idling phases.
// ----------------------------------------------------------------------------
module tb;

    localparam int NUM_FLOWS   = 16;
    localparam int QUEUE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int N_RANDOM    = 1400;

    typedef enum logic { OP_ENQUEUE = 1'b0, OP_DEQUEUE = 1'b1 } op_e;

    typedef struct packed {
        op_e                         op;
        logic [lass_pkg::FLOW_W-1:0] flow;
        logic [lass_pkg::LEN_W-1:0]  len;
        logic [lass_pkg::TAG_W-1:0]  tag;
    } request_t;

    typedef struct packed {
        logic                        got;
        logic [lass_pkg::FLOW_W-1:0] flow;
        logic [lass_pkg::LEN_W-1:0]  len;
        logic [lass_pkg::TAG_W-1:0]  tag;
        logic                        dropped;
        logic                        all_empty;
    } grant_t;

    // one stimulus row: the request and, where obvious, the result it must give
    typedef struct packed {
        request_t rq;
        logic     typed;
        grant_t   want;
    } row_t;

    logic clk;
    logic rst_n;

    lass_in_if  req ();
    lass_out_if res ();

    least_attained_service_scheduler_core #(
        .NUM_FLOWS   (NUM_FLOWS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .res   (res.source)
    );

    // ------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    int cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Queue model: per-flow FIFOs and attained-service counters
    // ------------------------------------------------------------------
    logic [lass_pkg::CNT_W-1:0]                 served  [NUM_FLOWS];
    int                                         held    [NUM_FLOWS];
    int                                         rd_slot [NUM_FLOWS];
    int                                         wr_slot [NUM_FLOWS];
    logic [lass_pkg::LEN_W+lass_pkg::TAG_W-1:0] slots   [NUM_FLOWS][QUEUE_DEPTH];

    function automatic grant_t schedule(request_t rq);
        grant_t g;
        int     best;
        logic [lass_pkg::LEN_W+lass_pkg::TAG_W-1:0] word;
        logic [lass_pkg::CNT_W:0]                   sum;
        g = '0;
        best = -1;
        if (rq.op == OP_ENQUEUE)
        begin
            // a full queue refuses the packet and leaves everything alone
            if (held[rq.flow] >= QUEUE_DEPTH)
                g.dropped = 1'b1;
            else
            begin
                slots[rq.flow][wr_slot[rq.flow]] = {rq.len, rq.tag};
                wr_slot[rq.flow] = (wr_slot[rq.flow] + 1) % QUEUE_DEPTH;
                held[rq.flow]++;
            end
        end
        else
        begin
            // least served non-empty flow; strict compare keeps the lowest index
            for (int f = 0; f < NUM_FLOWS; f++)
                if (held[f] != 0 && (best < 0 || served[f] < served[best]))
                    best = f;
            if (best >= 0)
            begin
                word = slots[best][rd_slot[best]];
                rd_slot[best] = (rd_slot[best] + 1) % QUEUE_DEPTH;
                held[best]--;
                sum = served[best]
                      + word[lass_pkg::LEN_W+lass_pkg::TAG_W-1:lass_pkg::TAG_W];
                served[best] = sum[lass_pkg::CNT_W] ? '1 : sum[lass_pkg::CNT_W-1:0];
                if (held[best] == 0)
                    served[best] = '0;
                g.got  = 1'b1;
                g.flow = best[lass_pkg::FLOW_W-1:0];
                g.len  = word[lass_pkg::LEN_W+lass_pkg::TAG_W-1:lass_pkg::TAG_W];
                g.tag  = word[lass_pkg::TAG_W-1:0];
            end
        end
        g.all_empty = 1'b1;
        for (int f = 0; f < NUM_FLOWS; f++)
            if (held[f] != 0)
                g.all_empty = 1'b0;
        return g;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: rows in flight and the grants still awaited
    // ------------------------------------------------------------------
    row_t   in_flight[$];
    grant_t awaited[$];
    bit     failed = 1'b0;

    // predict on every accepted request; typed rows override the model
    always @(posedge clk)
    begin
        row_t   r;
        grant_t g;
        if (rst_n && req.valid && req.ready)
        begin
            r = in_flight.pop_front();
            g = schedule(r.rq);
            awaited.push_back(r.typed ? r.want : g);
        end
    end

    // compare every accepted result with the oldest expectation
    always @(posedge clk)
    begin
        grant_t seen;
        grant_t want;
        if (rst_n && res.valid && res.ready)
        begin
            seen = '{res.out_valid, res.out_flow, res.out_length, res.out_tag,
                     res.dropped, res.all_empty};
            if (awaited.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual %p", $time, seen);
                failed = 1'b1;
            end
            else
            begin
                want = awaited.pop_front();
                if (seen !== want)
                begin
                    $display("%0t: expected %p, actual %p", $time, want, seen);
                    failed = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls plus an optional long hold-off
    // ------------------------------------------------------------------
    int stall_pct  = 0;
    bit hold_start = 1'b0;
    int hold_left  = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else
        begin
            if (hold_start)
            begin
                hold_start = 1'b0;
                hold_left  = 400;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                res.ready <= 1'b0;
            end
            else
                res.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    int idle_pct = 0;

    // hold valid through the handshake; gaps only between items
    task automatic offer(row_t r);
        while ($urandom_range(99) < idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        in_flight.push_back(r);
        req.valid         <= 1'b1;
        req.mode          <= r.rq.op;
        req.flow_index    <= r.rq.flow;
        req.packet_length <= r.rq.len;
        req.packet_tag    <= r.rq.tag;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    function automatic row_t plain(op_e op, int flow, int len, int tag);
        row_t r;
        r = '0;
        r.rq = '{op, flow[lass_pkg::FLOW_W-1:0], len[lass_pkg::LEN_W-1:0],
                 tag[lass_pkg::TAG_W-1:0]};
        return r;
    endfunction

    function automatic row_t fixed(row_t r, grant_t want);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    // random traffic; a narrow flow span fills queues up and forces drops
    function automatic row_t random_row(int enq_pct, int flow_span);
        int len;
        case ($urandom_range(9))
            0:       len = 0;
            1:       len = 16'hFFFF;
            default: len = $urandom_range(16'hFFFF);
        endcase
        return plain(($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE,
                     $urandom_range(flow_span - 1), len, $urandom_range(16'hFFFF));
    endfunction

    row_t table_rows[$];

    initial
    begin
        int enq_pct;
        int span;

        for (int f = 0; f < NUM_FLOWS; f++)
        begin
            served[f]  = '0;
            held[f]    = 0;
            rd_slot[f] = 0;
            wr_slot[f] = 0;
        end

        req.valid         <= 1'b0;
        req.mode          <= OP_ENQUEUE;
        req.flow_index    <= '0;
        req.packet_length <= '0;
        req.packet_tag    <= '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows: empty dequeue, field extremes, ties, a full queue
        table_rows.push_back(fixed(plain(OP_DEQUEUE, 9, 16'hFFFF, 16'hFFFF),
                                   '{1'b0, 4'd0, 16'd0, 16'd0, 1'b0, 1'b1}));
        table_rows.push_back(fixed(plain(OP_ENQUEUE, 15, 16'hFFFF, 16'hFFFF),
                                   '{1'b0, 4'd0, 16'd0, 16'd0, 1'b0, 1'b0}));
        table_rows.push_back(fixed(plain(OP_DEQUEUE, 0, 0, 0),
                                   '{1'b1, 4'd15, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1}));
        table_rows.push_back(fixed(plain(OP_ENQUEUE, 0, 0, 0),
                                   '{1'b0, 4'd0, 16'd0, 16'd0, 1'b0, 1'b0}));
        table_rows.push_back(plain(OP_ENQUEUE, 0, 300, 16'h1234));
        table_rows.push_back(plain(OP_ENQUEUE, 5, 40, 16'hA5A5));
        table_rows.push_back(plain(OP_ENQUEUE, 5, 7, 16'h5A5A));
        table_rows.push_back(plain(OP_DEQUEUE, 0, 0, 0));
        table_rows.push_back(plain(OP_DEQUEUE, 0, 0, 0));
        table_rows.push_back(plain(OP_DEQUEUE, 0, 0, 0));
        for (int i = 0; i < QUEUE_DEPTH; i++)
            table_rows.push_back(plain(OP_ENQUEUE, 7, i * 4099, 16'hF00 + i));
        table_rows.push_back(fixed(plain(OP_ENQUEUE, 7, 1, 1),
                                   '{1'b0, 4'd0, 16'd0, 16'd0, 1'b1, 1'b0}));
        table_rows.push_back(plain(OP_DEQUEUE, 0, 0, 0));

        @(posedge clk);
        foreach (table_rows[i])
            offer(table_rows[i]);

        // random part in idling phases; the long hold-off lands in the first
        for (int n = 0; n < N_RANDOM; n++)
        begin
            case (n / 280)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 61; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 61; end
                3:       begin idle_pct = 15; stall_pct = 15; end
                default: begin idle_pct = 0;  stall_pct = 0;  end
            endcase
            if (n == 40)
                hold_start = 1'b1;
            // swing between filling and draining so queues run full and empty
            enq_pct = ((n / 60) % 2 == 0) ? 75 : 35;
            span    = ((n / 120) % 3 == 0) ? 3 : NUM_FLOWS;
            offer(random_row(enq_pct, span));
        end
        req.valid <= 1'b0;
        stall_pct = 0;

        while (awaited.size() != 0 || in_flight.size() != 0)
            @(posedge clk);
        repeat (4 * NUM_FLOWS) @(posedge clk);

        if (!failed)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[least_attained_service_scheduler_core.f]
hdl/lass_pkg.sv
hdl/lass_in_if.sv
hdl/lass_out_if.sv
hdl/lass_cell.sv
hdl/least_attained_service_scheduler_core.sv
sim/tb.sv
